### src/robin_hood_hash_set_macros.svh
// Assertion macros for the robin hood hash set
`ifndef ROBIN_HOOD_HASH_SET_MACROS_SVH
`define ROBIN_HOOD_HASH_SET_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RHHS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rhhs assertion failed");
// next-cycle implication
`define RHHS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rhhs assertion failed");
`else
`define RHHS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RHHS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/rhhs_pkg.sv
// Shared types and constants of the robin hood hash set
package rhhs_pkg;

    // request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // mixer and generator constants
    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          FMIX_SHIFT = 33;
    localparam logic [63:0] PRNG_SEED  = 64'd88172645463325252;
    localparam int          XS_A       = 13;
    localparam int          XS_B       = 7;
    localparam int          XS_C       = 17;

    localparam logic [9:0]  FILL_RESET = 10'd512;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_HASH_TGT, CMD_HOME, CMD_RD_SLOT,
        CMD_HASH_SLOT, CMD_STEP, CMD_FOUND, CMD_INS_DENSE, CMD_INS_PLACE,
        CMD_INS_SWAP, CMD_RD_LAST, CMD_LAST, CMD_MOVE, CMD_DEL_START,
        CMD_SHIFT, CMD_DEL_CLR, CMD_MOD_LIM, CMD_SET_LIM, CMD_DRAW,
        CMD_MOD_DRAW, CMD_RD_SAMPLE, CMD_RESULT
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t  code;
        logic [2:0] res_status;
        logic       res_sample;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       key_rsv;
        logic       count_zero;
        logic       full;
        logic       hash_busy;
        logic       mod_busy;
        logic       slot_empty;
        logic       slot_match;
        logic       od_lt;
        logic       home_eq;
        logic       last_eq;
        logic       draw_ok;
        logic       out_full;
        logic       clr_last;
    } dp_stat_t;

endpackage

### src/rhhs_ram.sv
// Generic single-write, single-read RAM with registered read data
module rhhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

### src/rhhs_hash.sv
// Iterative fmix64 mixer: one 32x32 partial product per cycle
module rhhs_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] din,
    output logic        busy,
    output logic [63:0] dout
);
    localparam logic [2:0] HS_MUL0 = 3'd0;
    localparam logic [2:0] HS_MUL1 = 3'd1;
    localparam logic [2:0] HS_MUL2 = 3'd2;
    localparam logic [2:0] HS_ADD  = 3'd3;
    localparam logic [2:0] HS_FOLD = 3'd4;

    logic        busy_reg;
    logic [2:0]  step_reg;
    logic        round_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] mul_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // operand selection for the shared multiplier
    assign mul_c = round_reg ? rhhs_pkg::FMIX_C2 : rhhs_pkg::FMIX_C1;
    assign mul_a = (step_reg == HS_MUL2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (step_reg == HS_MUL1) ? mul_c[63:32] : mul_c[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == HS_FOLD && round_reg) begin
            busy_reg <= 1'b0;
        end
    end

    // multiply-xorshift sequence, two rounds
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg     <= din ^ (din >> rhhs_pkg::FMIX_SHIFT);
            step_reg  <= HS_MUL0;
            round_reg <= 1'b0;
        end else if (busy_reg) begin
            unique case (step_reg)
                HS_MUL0: begin
                    prod_reg <= mul_p;
                    step_reg <= HS_MUL1;
                end
                HS_MUL1: begin
                    acc_reg  <= prod_reg;
                    prod_reg <= mul_p;
                    step_reg <= HS_MUL2;
                end
                HS_MUL2: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    prod_reg       <= mul_p;
                    step_reg       <= HS_ADD;
                end
                HS_ADD: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    step_reg       <= HS_FOLD;
                end
                default: begin
                    x_reg     <= acc_reg ^ (acc_reg >> rhhs_pkg::FMIX_SHIFT);
                    step_reg  <= HS_MUL0;
                    round_reg <= 1'b1;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign dout = x_reg;
endmodule

### src/rhhs_dp.sv
// Datapath: table and dense memories, hash unit, modulo unit, PRNG, result register
module rhhs_dp #(
    parameter int TABLE_SLOTS = 1024,
    parameter int DENSE_SLOTS = 512
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rhhs_pkg::ctrl_cmd_t cmd,
    output rhhs_pkg::dp_stat_t  stat,
    input  logic [1:0]          s_opcode,
    input  logic [63:0]         s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [63:0]         m_sample_key,
    output logic [9:0]          m_member_count,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data
);
    localparam int SW      = $clog2(TABLE_SLOTS);
    localparam int DW      = $clog2(DENSE_SLOTS);
    localparam int CW      = $clog2(DENSE_SLOTS + 1);
    localparam int LIM_CAP = (DENSE_SLOTS < TABLE_SLOTS - 1) ? DENSE_SLOTS : TABLE_SLOTS - 1;

    // request and walk registers
    logic [1:0]    op_reg;
    logic [63:0]   key_reg;
    logic [63:0]   tgt_reg;
    logic [SW-1:0] pos_reg;
    logic [SW-1:0] home_reg;
    logic [SW:0]   dist_reg;
    logic [SW-1:0] found_pos_reg;
    logic [SW-1:0] i_reg;
    logic [63:0]   carry_key_reg;
    logic [DW-1:0] carry_idx_reg;
    logic [DW-1:0] del_idx_reg;
    logic [SW-1:0] clr_cnt_reg;
    logic [CW-1:0] count_reg;
    logic [9:0]    fill_reg;
    logic [63:0]   prng_reg;
    logic [31:0]   lim_reg;
    logic [CW-1:0] rem_reg;
    logic [31:0]   dvd_reg;
    logic [4:0]    mod_cnt_reg;
    logic          mod_busy_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [63:0]   out_sample_reg;
    logic [9:0]    out_count_reg;

    // memory ports
    logic          sk_we, si_we, dk_we, slot_re, dk_re;
    logic [SW-1:0] sk_wa, si_wa;
    logic [63:0]   sk_wd, dk_wd;
    logic [DW-1:0] si_wd, dk_wa, dk_ra;
    logic [63:0]   sk_rd, dk_rd;
    logic [DW-1:0] si_rd;

    logic          hash_start;
    logic [63:0]   hash_din;
    logic          hash_busy;
    logic [63:0]   hash_out;
    logic [SW-1:0] hash_home;
    logic [SW-1:0] od;
    logic [CW-1:0] count_m1;
    logic [CW:0]   mod_trial;
    logic [63:0]   prng_a, prng_b, prng_c;

    rhhs_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_slot_key (
        .aclk(aclk), .wr_en(sk_we), .wr_addr(sk_wa), .wr_data(sk_wd),
        .rd_en(slot_re), .rd_addr(pos_reg), .rd_data(sk_rd)
    );
    rhhs_ram #(.WIDTH(DW), .DEPTH(TABLE_SLOTS)) u_slot_idx (
        .aclk(aclk), .wr_en(si_we), .wr_addr(si_wa), .wr_data(si_wd),
        .rd_en(slot_re), .rd_addr(pos_reg), .rd_data(si_rd)
    );
    rhhs_ram #(.WIDTH(64), .DEPTH(DENSE_SLOTS)) u_dense (
        .aclk(aclk), .wr_en(dk_we), .wr_addr(dk_wa), .wr_data(dk_wd),
        .rd_en(dk_re), .rd_addr(dk_ra), .rd_data(dk_rd)
    );

    assign hash_start = (cmd.code == rhhs_pkg::CMD_HASH_TGT) ||
                        (cmd.code == rhhs_pkg::CMD_HASH_SLOT);
    assign hash_din   = (cmd.code == rhhs_pkg::CMD_HASH_SLOT) ? sk_rd : tgt_reg;

    rhhs_hash u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(hash_start), .din(hash_din),
        .busy(hash_busy), .dout(hash_out)
    );

    assign hash_home = hash_out[SW-1:0];
    assign od        = pos_reg - hash_home;
    assign count_m1  = count_reg - CW'(1);
    assign mod_trial = {rem_reg, dvd_reg[31]};

    // xorshift64 step
    assign prng_a = prng_reg ^ (prng_reg << rhhs_pkg::XS_A);
    assign prng_b = prng_a ^ (prng_a >> rhhs_pkg::XS_B);
    assign prng_c = prng_b ^ (prng_b << rhhs_pkg::XS_C);

    // memory port steering
    always_comb begin
        sk_we   = 1'b0;
        sk_wa   = pos_reg;
        sk_wd   = carry_key_reg;
        si_we   = 1'b0;
        si_wa   = pos_reg;
        si_wd   = carry_idx_reg;
        dk_we   = 1'b0;
        dk_wa   = count_reg[DW-1:0];
        dk_wd   = key_reg;
        slot_re = (cmd.code == rhhs_pkg::CMD_RD_SLOT);
        dk_re   = 1'b0;
        dk_ra   = count_m1[DW-1:0];
        unique case (cmd.code)
            rhhs_pkg::CMD_CLEAR: begin
                sk_we = 1'b1;
                sk_wa = clr_cnt_reg;
                sk_wd = '0;
            end
            rhhs_pkg::CMD_INS_DENSE: dk_we = 1'b1;
            rhhs_pkg::CMD_INS_PLACE, rhhs_pkg::CMD_INS_SWAP: begin
                sk_we = 1'b1;
                si_we = 1'b1;
            end
            rhhs_pkg::CMD_MOVE: begin
                dk_we = 1'b1;
                dk_wa = del_idx_reg;
                dk_wd = tgt_reg;
                si_we = 1'b1;
                si_wd = del_idx_reg;
            end
            rhhs_pkg::CMD_SHIFT: begin
                sk_we = 1'b1;
                sk_wa = i_reg;
                sk_wd = sk_rd;
                si_we = 1'b1;
                si_wa = i_reg;
                si_wd = si_rd;
            end
            rhhs_pkg::CMD_DEL_CLR: begin
                sk_we = 1'b1;
                sk_wa = i_reg;
                sk_wd = '0;
            end
            rhhs_pkg::CMD_RD_LAST: dk_re = 1'b1;
            rhhs_pkg::CMD_RD_SAMPLE: begin
                dk_re = 1'b1;
                dk_ra = rem_reg[DW-1:0];
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            fill_reg      <= rhhs_pkg::FILL_RESET;
            prng_reg      <= rhhs_pkg::PRNG_SEED;
            mod_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fill_reg <= cfg_wr_data;
            end
            if (cmd.code == rhhs_pkg::CMD_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
            if (cmd.code == rhhs_pkg::CMD_INS_DENSE) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.code == rhhs_pkg::CMD_DEL_START) begin
                count_reg <= count_m1;
            end
            if (cmd.code == rhhs_pkg::CMD_DRAW) begin
                prng_reg <= prng_c;
            end
            if (cmd.code == rhhs_pkg::CMD_MOD_LIM || cmd.code == rhhs_pkg::CMD_MOD_DRAW) begin
                mod_busy_reg <= 1'b1;
            end else if (mod_busy_reg && mod_cnt_reg == 5'd31) begin
                mod_busy_reg <= 1'b0;
            end
            if (cmd.code == rhhs_pkg::CMD_RESULT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        // restoring modulo, one dividend bit per cycle
        if (cmd.code == rhhs_pkg::CMD_MOD_LIM || cmd.code == rhhs_pkg::CMD_MOD_DRAW) begin
            dvd_reg     <= (cmd.code == rhhs_pkg::CMD_MOD_LIM) ? 32'hFFFF_FFFF : prng_reg[31:0];
            rem_reg     <= '0;
            mod_cnt_reg <= '0;
        end else if (mod_busy_reg) begin
            rem_reg     <= (mod_trial >= {1'b0, count_reg}) ?
                           CW'(mod_trial - {1'b0, count_reg}) : CW'(mod_trial);
            dvd_reg     <= dvd_reg << 1;
            mod_cnt_reg <= mod_cnt_reg + 5'd1;
        end
        unique case (cmd.code)
            rhhs_pkg::CMD_LOAD: begin
                op_reg  <= s_opcode;
                key_reg <= s_key;
                tgt_reg <= s_key;
            end
            rhhs_pkg::CMD_HOME: begin
                pos_reg  <= hash_home;
                home_reg <= hash_home;
                dist_reg <= '0;
            end
            rhhs_pkg::CMD_STEP: begin
                pos_reg  <= pos_reg + SW'(1);
                dist_reg <= dist_reg + (SW+1)'(1);
            end
            rhhs_pkg::CMD_FOUND: begin
                found_pos_reg <= pos_reg;
                del_idx_reg   <= si_rd;
            end
            rhhs_pkg::CMD_INS_DENSE: begin
                carry_key_reg <= key_reg;
                carry_idx_reg <= count_reg[DW-1:0];
                pos_reg       <= home_reg;
                dist_reg      <= '0;
            end
            rhhs_pkg::CMD_INS_SWAP: begin
                carry_key_reg <= sk_rd;
                carry_idx_reg <= si_rd;
                dist_reg      <= {1'b0, od};
            end
            rhhs_pkg::CMD_LAST: tgt_reg <= dk_rd;
            rhhs_pkg::CMD_DEL_START: begin
                i_reg   <= found_pos_reg;
                pos_reg <= found_pos_reg + SW'(1);
            end
            rhhs_pkg::CMD_SHIFT: begin
                i_reg   <= pos_reg;
                pos_reg <= pos_reg + SW'(1);
            end
            rhhs_pkg::CMD_SET_LIM: lim_reg <= 32'hFFFF_FFFF - 32'(rem_reg);
            rhhs_pkg::CMD_RESULT: begin
                out_status_reg <= cmd.res_status;
                out_sample_reg <= cmd.res_sample ? dk_rd : 64'd0;
                out_count_reg  <= 10'(count_reg);
            end
            default: ;
        endcase
    end

    // status toward the controller
    always_comb begin
        stat.op         = op_reg;
        stat.key_rsv    = (key_reg[63:1] == '0);
        stat.count_zero = (count_reg == '0);
        stat.full       = (32'(count_reg) >= 32'(fill_reg)) || (32'(count_reg) >= 32'(LIM_CAP));
        stat.hash_busy  = hash_busy;
        stat.mod_busy   = mod_busy_reg;
        stat.slot_empty = (sk_rd == '0);
        stat.slot_match = (sk_rd == tgt_reg);
        stat.od_lt      = ({1'b0, od} < dist_reg);
        stat.home_eq    = (hash_home == pos_reg);
        stat.last_eq    = (dk_rd == key_reg);
        stat.draw_ok    = (prng_reg[31:0] < lim_reg);
        stat.out_full   = out_valid_reg && !m_ready;
        stat.clr_last   = (clr_cnt_reg == {SW{1'b1}});
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_sample_key   = out_sample_reg;
    assign m_member_count = out_count_reg;
endmodule

### src/rhhs_ctrl.sv
// Controller: sequences lookup, insert, backward-shift delete and sampling
module rhhs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rhhs_pkg::dp_stat_t  stat,
    output rhhs_pkg::ctrl_cmd_t cmd
);
    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_LHASH = 5'd3;
    localparam logic [4:0] S_LHW   = 5'd4;
    localparam logic [4:0] S_LRD   = 5'd5;
    localparam logic [4:0] S_LCHK  = 5'd6;
    localparam logic [4:0] S_LSW   = 5'd7;
    localparam logic [4:0] S_LHIT  = 5'd8;
    localparam logic [4:0] S_LMISS = 5'd9;
    localparam logic [4:0] S_IRD   = 5'd10;
    localparam logic [4:0] S_ICHK  = 5'd11;
    localparam logic [4:0] S_IW    = 5'd12;
    localparam logic [4:0] S_ISTEP = 5'd13;
    localparam logic [4:0] S_DRDL  = 5'd14;
    localparam logic [4:0] S_DLAST = 5'd15;
    localparam logic [4:0] S_DSH0  = 5'd16;
    localparam logic [4:0] S_DRD   = 5'd17;
    localparam logic [4:0] S_DCHK  = 5'd18;
    localparam logic [4:0] S_DW    = 5'd19;
    localparam logic [4:0] S_SLIM  = 5'd20;
    localparam logic [4:0] S_SLW   = 5'd21;
    localparam logic [4:0] S_SDRAW = 5'd22;
    localparam logic [4:0] S_SDCHK = 5'd23;
    localparam logic [4:0] S_SMW   = 5'd24;
    localparam logic [4:0] S_SRD   = 5'd25;
    localparam logic [4:0] S_DONE  = 5'd26;

    logic [4:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic [2:0] rs_reg, rs_next;
    logic       smp_reg, smp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            pass_reg  <= 1'b0;
            rs_reg    <= rhhs_pkg::ST_OK;
            smp_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            rs_reg    <= rs_next;
            smp_reg   <= smp_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        rs_next        = rs_reg;
        smp_next       = smp_reg;
        cmd.code       = rhhs_pkg::CMD_NONE;
        cmd.res_status = rs_reg;
        cmd.res_sample = smp_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.code = rhhs_pkg::CMD_CLEAR;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.code   = rhhs_pkg::CMD_LOAD;
                    pass_next  = 1'b0;
                    smp_next   = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_DONE;
                unique case (stat.op)
                    rhhs_pkg::OP_INSERT: begin
                        if (stat.key_rsv) rs_next = rhhs_pkg::ST_RESERVED;
                        else state_next = S_LHASH;
                    end
                    rhhs_pkg::OP_DELETE: begin
                        if (stat.key_rsv || stat.count_zero) rs_next = rhhs_pkg::ST_NOTFOUND;
                        else state_next = S_LHASH;
                    end
                    rhhs_pkg::OP_SAMPLE: begin
                        if (stat.count_zero) rs_next = rhhs_pkg::ST_EMPTY;
                        else state_next = S_SLIM;
                    end
                    default: rs_next = rhhs_pkg::ST_OK;
                endcase
            end
            // probe walk of a lookup
            S_LHASH: begin
                cmd.code   = rhhs_pkg::CMD_HASH_TGT;
                state_next = S_LHW;
            end
            S_LHW: begin
                if (!stat.hash_busy) begin
                    cmd.code   = rhhs_pkg::CMD_HOME;
                    state_next = S_LRD;
                end
            end
            S_LRD: begin
                cmd.code   = rhhs_pkg::CMD_RD_SLOT;
                state_next = S_LCHK;
            end
            S_LCHK: begin
                priority if (stat.slot_empty) begin
                    state_next = S_LMISS;
                end else if (stat.slot_match) begin
                    state_next = S_LHIT;
                end else begin
                    cmd.code   = rhhs_pkg::CMD_HASH_SLOT;
                    state_next = S_LSW;
                end
            end
            S_LSW: begin
                if (!stat.hash_busy) begin
                    if (stat.od_lt) begin
                        state_next = S_LMISS;
                    end else begin
                        cmd.code   = rhhs_pkg::CMD_STEP;
                        state_next = S_LRD;
                    end
                end
            end
            S_LHIT: begin
                priority if (pass_reg) begin
                    cmd.code   = rhhs_pkg::CMD_MOVE;
                    state_next = S_DSH0;
                end else if (stat.op == rhhs_pkg::OP_INSERT) begin
                    rs_next    = rhhs_pkg::ST_DUP;
                    state_next = S_DONE;
                end else begin
                    cmd.code   = rhhs_pkg::CMD_FOUND;
                    state_next = S_DRDL;
                end
            end
            S_LMISS: begin
                priority if (pass_reg) begin
                    state_next = S_DSH0;
                end else if (stat.op == rhhs_pkg::OP_INSERT) begin
                    if (stat.full) begin
                        rs_next    = rhhs_pkg::ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        cmd.code   = rhhs_pkg::CMD_INS_DENSE;
                        state_next = S_IRD;
                    end
                end else begin
                    rs_next    = rhhs_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
            end
            // insert walk with displacement
            S_IRD: begin
                cmd.code   = rhhs_pkg::CMD_RD_SLOT;
                state_next = S_ICHK;
            end
            S_ICHK: begin
                if (stat.slot_empty) begin
                    cmd.code   = rhhs_pkg::CMD_INS_PLACE;
                    rs_next    = rhhs_pkg::ST_OK;
                    state_next = S_DONE;
                end else begin
                    cmd.code   = rhhs_pkg::CMD_HASH_SLOT;
                    state_next = S_IW;
                end
            end
            S_IW: begin
                if (!stat.hash_busy) begin
                    if (stat.od_lt) begin
                        cmd.code   = rhhs_pkg::CMD_INS_SWAP;
                        state_next = S_ISTEP;
                    end else begin
                        cmd.code   = rhhs_pkg::CMD_STEP;
                        state_next = S_IRD;
                    end
                end
            end
            S_ISTEP: begin
                cmd.code   = rhhs_pkg::CMD_STEP;
                state_next = S_IRD;
            end
            // delete: refill the dense hole, then backward shift
            S_DRDL: begin
                cmd.code   = rhhs_pkg::CMD_RD_LAST;
                state_next = S_DLAST;
            end
            S_DLAST: begin
                cmd.code = rhhs_pkg::CMD_LAST;
                if (stat.last_eq) begin
                    state_next = S_DSH0;
                end else begin
                    pass_next  = 1'b1;
                    state_next = S_LHASH;
                end
            end
            S_DSH0: begin
                cmd.code   = rhhs_pkg::CMD_DEL_START;
                state_next = S_DRD;
            end
            S_DRD: begin
                cmd.code   = rhhs_pkg::CMD_RD_SLOT;
                state_next = S_DCHK;
            end
            S_DCHK: begin
                if (stat.slot_empty) begin
                    cmd.code   = rhhs_pkg::CMD_DEL_CLR;
                    rs_next    = rhhs_pkg::ST_OK;
                    state_next = S_DONE;
                end else begin
                    cmd.code   = rhhs_pkg::CMD_HASH_SLOT;
                    state_next = S_DW;
                end
            end
            S_DW: begin
                if (!stat.hash_busy) begin
                    if (stat.home_eq) begin
                        cmd.code   = rhhs_pkg::CMD_DEL_CLR;
                        rs_next    = rhhs_pkg::ST_OK;
                        state_next = S_DONE;
                    end else begin
                        cmd.code   = rhhs_pkg::CMD_SHIFT;
                        state_next = S_DRD;
                    end
                end
            end
            // sample: rejection bound, draw, reduce
            S_SLIM: begin
                cmd.code   = rhhs_pkg::CMD_MOD_LIM;
                state_next = S_SLW;
            end
            S_SLW: begin
                if (!stat.mod_busy) begin
                    cmd.code   = rhhs_pkg::CMD_SET_LIM;
                    state_next = S_SDRAW;
                end
            end
            S_SDRAW: begin
                cmd.code   = rhhs_pkg::CMD_DRAW;
                state_next = S_SDCHK;
            end
            S_SDCHK: begin
                if (stat.draw_ok) begin
                    cmd.code   = rhhs_pkg::CMD_MOD_DRAW;
                    state_next = S_SMW;
                end else begin
                    state_next = S_SDRAW;
                end
            end
            S_SMW: begin
                if (!stat.mod_busy) begin
                    cmd.code   = rhhs_pkg::CMD_RD_SAMPLE;
                    state_next = S_SRD;
                end
            end
            S_SRD: begin
                smp_next   = 1'b1;
                rs_next    = rhhs_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_full) begin
                    cmd.code   = rhhs_pkg::CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

### src/robin_hood_hash_set.sv
// One transaction at a time; a stalled result holds the next. An insert walks its probe
// sequence twice (lookup, then insert), each occupied slot costing a slot read and an fmix
// hash, plus a swap per displacement; a delete probes and shifts slots, probing again when
// the last dense member moves; a sample runs two 32-bit modulo reductions and redraws per
// rejected draw. Reset (synchronous, aresetn low): count 0, PRNG reseeded, fill_limit 512,
// then a clearing pass over every slot zeroes the slot key memory before s_ready rises.
module robin_hood_hash_set #(
    parameter int TABLE_SLOTS = 1024,
    parameter int DENSE_SLOTS = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_sample_key,
    output logic [9:0]  m_member_count,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data
);
`include "robin_hood_hash_set_macros.svh"

    rhhs_pkg::ctrl_cmd_t cmd;
    rhhs_pkg::dp_stat_t  stat;

    rhhs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    rhhs_dp #(.TABLE_SLOTS(TABLE_SLOTS), .DENSE_SLOTS(DENSE_SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_opcode(s_opcode), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_sample_key(m_sample_key), .m_member_count(m_member_count),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // checks
    `RHHS_ASSERT_IMP(a_result_room, aclk, aresetn, cmd.code == rhhs_pkg::CMD_RESULT, !stat.out_full)
    `RHHS_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `RHHS_ASSERT_IMP(a_count_cap, aclk, aresetn, m_valid, m_member_count <= DENSE_SLOTS)
    `RHHS_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status <= rhhs_pkg::ST_EMPTY)
endmodule

### tb/rhhs_checker.sv
// Scoreboard for the robin hood hash set: watches both channels, predicts and compares
`timescale 1ns / 100ps
module rhhs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_key,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [63:0] m_sample_key,
    input  logic [9:0]  m_member_count,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    output int          fail_count,
    output int          pending
);
    localparam int NSLOT  = 1024;
    localparam int NDENSE = 512;
    localparam logic [9:0] MASK = 10'(NSLOT - 1);

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] sample_key;
        logic [9:0]  count;
    } answer_t;

    // shadow copy of the set
    logic [63:0] sh_key   [NSLOT];
    logic [8:0]  sh_dix   [NSLOT];
    logic [63:0] sh_dense [NDENSE];
    logic [9:0]  sh_count;
    logic [63:0] sh_prng;
    logic [9:0]  sh_fill;

    answer_t answers_due[$];

    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x >> rhhs_pkg::FMIX_SHIFT);
        x = x * rhhs_pkg::FMIX_C1;
        x = x ^ (x >> rhhs_pkg::FMIX_SHIFT);
        x = x * rhhs_pkg::FMIX_C2;
        x = x ^ (x >> rhhs_pkg::FMIX_SHIFT);
        return x;
    endfunction

    function automatic logic [9:0] home(input logic [63:0] k);
        logic [63:0] m;
        m = mix64(k);
        return m[9:0] & MASK;
    endfunction

    // probe for a key; stops at an empty slot or a richer resident
    function automatic logic find_slot(input logic [63:0] k, output logic [9:0] where);
        logic [9:0] pos;
        int probe_len;
        pos = home(k);
        probe_len = 0;
        where = '0;
        for (int n = 0; n < NSLOT; n++) begin
            if (sh_key[pos] == 64'd0) return 1'b0;
            if (sh_key[pos] == k) begin
                where = pos;
                return 1'b1;
            end
            if (int'((pos - home(sh_key[pos])) & MASK) < probe_len) return 1'b0;
            pos = (pos + 10'd1) & MASK;
            probe_len++;
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] add_key(input logic [63:0] key_in);
        logic [63:0] k, tk;
        logic [9:0] pos, w;
        logic [8:0] ix, ti;
        int probe_len, od, lim;
        k = key_in;
        if (k <= 64'd1) return rhhs_pkg::ST_RESERVED;
        if (find_slot(k, w)) return rhhs_pkg::ST_DUP;
        lim = sh_fill;
        if (lim > NDENSE) lim = NDENSE;
        if (lim > NSLOT - 1) lim = NSLOT - 1;
        if (int'(sh_count) >= lim) return rhhs_pkg::ST_FULL;
        ix = sh_count[8:0];
        sh_dense[ix] = k;
        sh_count++;
        pos = home(k);
        probe_len = 0;
        for (int n = 0; n < NSLOT; n++) begin
            if (sh_key[pos] == 64'd0) begin
                sh_key[pos] = k;
                sh_dix[pos] = ix;
                return rhhs_pkg::ST_OK;
            end
            od = int'((pos - home(sh_key[pos])) & MASK);
            if (od < probe_len) begin
                // displace the richer resident
                tk = sh_key[pos];
                ti = sh_dix[pos];
                sh_key[pos] = k;
                sh_dix[pos] = ix;
                k = tk;
                ix = ti;
                probe_len = od;
            end
            pos = (pos + 10'd1) & MASK;
            probe_len++;
        end
        return rhhs_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] drop_key(input logic [63:0] k);
        logic [9:0] pos, lp, i, j;
        logic [8:0] ix;
        logic [63:0] last;
        if (k <= 64'd1 || sh_count == 0) return rhhs_pkg::ST_NOTFOUND;
        if (!find_slot(k, pos)) return rhhs_pkg::ST_NOTFOUND;
        ix = sh_dix[pos];
        last = sh_dense[9'(sh_count - 10'd1)];
        // last dense member fills the hole
        if (last != k && find_slot(last, lp)) begin
            sh_dense[ix] = last;
            sh_dix[lp] = ix;
        end
        sh_count--;
        // backward shift
        i = pos;
        j = (pos + 10'd1) & MASK;
        for (int n = 0; n < NSLOT && sh_key[j] != 64'd0; n++) begin
            if (home(sh_key[j]) == j) break;
            sh_key[i] = sh_key[j];
            sh_dix[i] = sh_dix[j];
            i = j;
            j = (j + 10'd1) & MASK;
        end
        sh_key[i] = 64'd0;
        return rhhs_pkg::ST_OK;
    endfunction

    function automatic answer_t serve(input logic [1:0] op, input logic [63:0] k);
        answer_t a;
        logic [31:0] n, lim, r;
        a = '0;
        unique case (op)
            rhhs_pkg::OP_INSERT: a.status = add_key(k);
            rhhs_pkg::OP_DELETE: a.status = drop_key(k);
            rhhs_pkg::OP_SAMPLE: begin
                if (sh_count == 0) begin
                    a.status = rhhs_pkg::ST_EMPTY;
                end else begin
                    n = 32'(sh_count);
                    lim = 32'hFFFF_FFFF - (32'hFFFF_FFFF % n);
                    do begin
                        sh_prng = sh_prng ^ (sh_prng << rhhs_pkg::XS_A);
                        sh_prng = sh_prng ^ (sh_prng >> rhhs_pkg::XS_B);
                        sh_prng = sh_prng ^ (sh_prng << rhhs_pkg::XS_C);
                        r = sh_prng[31:0];
                    end while (r >= lim);
                    a.sample_key = sh_dense[9'(r % n)];
                end
            end
            default: ;
        endcase
        a.count = sh_count;
        return a;
    endfunction

    // predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                sh_key[i] = '0;
                sh_dix[i] = '0;
            end
            for (int i = 0; i < NDENSE; i++) sh_dense[i] = '0;
            sh_count = '0;
            sh_prng = rhhs_pkg::PRNG_SEED;
            sh_fill = rhhs_pkg::FILL_RESET;
            answers_due.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_wr_en) sh_fill = cfg_wr_data;
            if (s_valid && s_ready) answers_due.push_back(serve(s_opcode, s_key));
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_sample_key !== want.sample_key) begin
                        $error("sample_key: expected %h, got %h", want.sample_key,
                               m_sample_key);
                        fail_count++;
                    end
                    if (m_member_count !== want.count) begin
                        $error("member_count: expected %0d, got %0d", want.count,
                               m_member_count);
                        fail_count++;
                    end
                end
            end
            pending = answers_due.size();
        end
    end
endmodule

### tb/robin_hood_hash_set_tb.sv
// Top of the robin hood hash set testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module robin_hood_hash_set_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = rhhs_pkg::OP_NONE;
    logic [63:0] s_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [63:0] m_sample_key;
    logic [9:0]  m_member_count;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    int          fail_count;
    int          pending;

    logic [63:0] key_pool[$];
    int          stall_left = 0;

    always #5 aclk = ~aclk;

    robin_hood_hash_set DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_sample_key(m_sample_key), .m_member_count(m_member_count),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    rhhs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_sample_key(m_sample_key), .m_member_count(m_member_count),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side: mostly ready, random stalls of mixed length
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one request transaction; valid stays high when there is no gap
    task automatic send(input logic [1:0] op, input logic [63:0] k, input int gap);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode = op;
        s_key = k;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_and_set(input logic [9:0] lim);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = lim;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [63:0] wide_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(input int count, input int pool_size, input int ins_pct);
        int r;
        logic [1:0] op;
        logic [63:0] k;
        key_pool.delete();
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back(($urandom_range(0, 3) == 0) ? 64'($urandom_range(2, 4000))
                                                           : wide_key());
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = rhhs_pkg::OP_INSERT;
            else if (r < ins_pct + (95 - ins_pct) / 2) op = rhhs_pkg::OP_DELETE;
            else if (r < 95) op = rhhs_pkg::OP_SAMPLE;
            else op = rhhs_pkg::OP_NONE;
            r = $urandom_range(0, 99);
            if (r < 80) k = key_pool[$urandom_range(0, pool_size - 1)];
            else if (r < 85) k = 64'($urandom_range(0, 1));
            else k = wide_key();
            send(op, k, pick_gap());
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reserved keys, empty set, unused opcode, extremes
        send(rhhs_pkg::OP_INSERT, 64'd0, 0);
        send(rhhs_pkg::OP_INSERT, 64'd1, 0);
        send(rhhs_pkg::OP_DELETE, 64'd1, 0);
        send(rhhs_pkg::OP_DELETE, 64'd5, 0);
        send(rhhs_pkg::OP_SAMPLE, 64'd0, 0);
        send(rhhs_pkg::OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(rhhs_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(rhhs_pkg::OP_INSERT, 64'd2, 0);
        send(rhhs_pkg::OP_INSERT, 64'd2, 1);
        send(rhhs_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 0);
        send(rhhs_pkg::OP_SAMPLE, 64'd0, 0);
        send(rhhs_pkg::OP_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 2);
        send(rhhs_pkg::OP_DELETE, 64'h1234, 0);
        send(rhhs_pkg::OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(rhhs_pkg::OP_DELETE, 64'd2, 0);
        send(rhhs_pkg::OP_DELETE, 64'h8000_0000_0000_0000, 0);
        send(rhhs_pkg::OP_DELETE, 64'd2, 0);
        send(rhhs_pkg::OP_SAMPLE, 64'd0, 0);

        // limit of one: duplicate checked before full, reserved before both
        drain_and_set(10'd1);
        send(rhhs_pkg::OP_INSERT, 64'hA5A5, 0);
        send(rhhs_pkg::OP_INSERT, 64'hA5A5, 0);
        send(rhhs_pkg::OP_INSERT, 64'h5A5A, 0);
        send(rhhs_pkg::OP_INSERT, 64'd1, 0);
        // limit of zero refuses inserts, while a delete still goes through
        drain_and_set(10'd0);
        send(rhhs_pkg::OP_INSERT, 64'h5A5A, 0);
        send(rhhs_pkg::OP_DELETE, 64'hA5A5, 0);

        drain_and_set(10'd1023);
        random_phase(300, 256, 70);
        drain_and_set(10'd16);
        random_phase(200, 40, 45);
        drain_and_set(10'd1);
        random_phase(80, 8, 45);
        drain_and_set(10'd512);
        random_phase(250, 120, 50);
        drain_and_set(10'($urandom_range(2, 511)));
        random_phase(170, 64, 50);

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end
endmodule
